// ===== sv/dexp_pkg.sv =====
// ----------------------------------------------------------------------------
// dexp_pkg
// Shared types and constants for the decimal expansion block.
// ----------------------------------------------------------------------------
package dexp_pkg;

  localparam int unsigned MaxFracDigits = 32;
  localparam int unsigned LimitW        = 6;
  localparam int unsigned DataW         = 64;

  localparam logic [1:0] StExact   = 2'd0;
  localparam logic [1:0] StPeriod  = 2'd1;
  localparam logic [1:0] StLoss    = 2'd2;
  localparam logic [1:0] StDivZero = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] numerator;
    logic [DataW-1:0] denominator;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        digit;
    logic [DataW-1:0]  quotient;
    logic [1:0]        status;
    logic [LimitW-1:0] period_start;
    logic [LimitW-1:0] digit_count;
    logic              is_last;
  } out_item_t;

  // search request sent along the cell chain
  typedef struct packed {
    logic             load;
    logic [DataW-1:0] value;
  } hist_ctl_t;

endpackage

// ===== sv/dexp_if.sv =====
// ----------------------------------------------------------------------------
// dexp_in_if / dexp_out_if / dexp_cfg_if
// Valid/ready channels of the decimal expansion block.
// ----------------------------------------------------------------------------
interface dexp_in_if;
  logic                valid;
  logic                ready;
  dexp_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dexp_out_if;
  logic                valid;
  logic                ready;
  dexp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dexp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dexp_pkg::LimitW-1:0]   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/dexp_cell.sv =====
// ----------------------------------------------------------------------------
// dexp_cell
// One history slot: holds a remainder and compares it against the probe.
// ----------------------------------------------------------------------------
module dexp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       shift_i,
  input  logic [dexp_pkg::DataW-1:0] prev_i,
  input  logic                       prev_vld_i,
  input  logic [dexp_pkg::DataW-1:0] probe_i,
  output logic [dexp_pkg::DataW-1:0] val_o,
  output logic                       vld_o,
  output logic                       hit_o
);
  logic [dexp_pkg::DataW-1:0] val_q;
  logic                       vld_q;

  // shift register: newest remainder enters cell 0, oldest moves deeper
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= prev_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= prev_i;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign hit_o = vld_q && (val_q == probe_i);
endmodule

// ===== sv/dexp_divider.sv =====
// ----------------------------------------------------------------------------
// dexp_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dexp_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dexp_pkg::DataW-1:0] num_i,
  input  logic [dexp_pkg::DataW-1:0] den_i,
  output logic                       done_o,
  output logic [dexp_pkg::DataW-1:0] quo_o,
  output logic [dexp_pkg::DataW-1:0] rem_o
);
  localparam int unsigned W = dexp_pkg::DataW;

  logic [W-1:0]         quo_q, den_q;
  logic [W:0]           rem_q;
  logic [$clog2(W):0]   cnt_q;
  logic                 busy_q;
  logic [W:0]           trial;
  logic [W:0]           diff;

  assign trial = {rem_q[W-1:0], quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ($clog2(W)+1)'(1);
        if (cnt_q == ($clog2(W)+1)'(W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q[W-1:0];
endmodule

// ===== sv/decimal_expansion_with_repetend.sv =====
// ----------------------------------------------------------------------------
// decimal_expansion_with_repetend
// Long division of numerator by denominator with repetend detection.
// ----------------------------------------------------------------------------
// Usage: an item on in_if (numerator, denominator) produces one item per
// fraction digit on out_if, then a closing item with is_last set carrying
// the whole part, status, period start and digit count. cfg_if writes the
// fraction digit limit (0 acts as 1, larger values clip to MAX_FRAC_DIGITS).
// The user must see that cfg_if is written only while the block is idle;
// the block itself does not enforce this. Flow: the whole part comes from a
// one-bit-per-cycle divider started at the accepting edge. Each fraction
// digit then passes S_CHECK, which checks the remainder against the history
// cell chain, S_SUB, the subtract loop that removes up to three denominators
// a cycle from ten times the remainder, and S_EMIT, which loads the digit
// into the output register. A final S_CHECK ends the loop and S_CLOSE loads
// the closing item; one item is in work at a time. A zero denominator loads
// its closing item at the accepting edge, a zero numerator loads its digit
// there and its closing item from S_CLOSE.
// The next input item is taken once the closing item has left.
// A stalled receiver holds the output register; the digit loop waits.
// Reset empties the history chain, sets the limit to 32 and leaves idle.
// ----------------------------------------------------------------------------
module decimal_expansion_with_repetend #(
  parameter int unsigned MAX_FRAC_DIGITS = dexp_pkg::MaxFracDigits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dexp_in_if.sink    in_if,
  dexp_out_if.source out_if,
  dexp_cfg_if.sink   cfg_if
);
  localparam int unsigned W  = dexp_pkg::DataW;
  localparam int unsigned LW = dexp_pkg::LimitW;
  localparam int unsigned N  = MAX_FRAC_DIGITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] cfg_q, limit;
  logic [W-1:0]  den_q, whole_q;
  logic [W-1:0]  rem_q;
  logic [W+3:0]  acc_q;
  logic [3:0]    dig_q;
  logic [LW-1:0] idx_q, pstart_q;
  logic [1:0]    st_q;
  logic          ovld_q;
  dexp_pkg::out_item_t opay_q, opay_d;

  logic          accept, den_zero, num_zero, load_out;
  logic          div_start, div_done;
  logic [W-1:0]  div_quo, div_rem;
  logic          shift, clear;
  logic [N-1:0]  hit;
  logic [W-1:0]  cval [N+1];
  logic [N:0]    cvld;
  logic          any_hit;
  logic [LW-1:0] hit_pos;
  logic [W+3:0]  sub_a, sub_b;
  logic [W+3:0]  denx;
  logic          out_free;

  assign out_free = !ovld_q || out_if.ready;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= LW'(32);
    else if (cfg_if.valid) cfg_q <= cfg_if.payload;
  end
  always_comb begin
    limit = cfg_q;
    if (limit == '0) limit = LW'(1);
    if (limit > LW'(N)) limit = LW'(N);
  end

  assign in_if.ready = (state_q == S_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;
  assign den_zero    = (in_if.payload.denominator == '0);
  assign num_zero    = (in_if.payload.numerator == '0);
  assign div_start   = accept && !den_zero && !num_zero;

  // output register loads on the short cases, each digit and the closing item
  assign load_out = (accept && (den_zero || num_zero)) ||
                    ((state_q == S_EMIT || state_q == S_CLOSE) && out_free);

  dexp_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(in_if.payload.numerator), .den_i(in_if.payload.denominator),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // history chain: cell 0 holds the newest recorded remainder, cell k the one recorded k digits before it
  assign cval[0] = rem_q;
  assign cvld[0] = 1'b1;
  assign shift   = (state_q == S_CHECK) && (rem_q != '0) && (idx_q < limit) && !any_hit;
  assign clear   = accept;
  for (genvar k = 0; k < N; k++) begin : g_cell
    dexp_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .clear_i(clear), .shift_i(shift),
      .prev_i(cval[k]), .prev_vld_i(cvld[k]), .probe_i(rem_q),
      .val_o(cval[k+1]), .vld_o(cvld[k+1]), .hit_o(hit[k])
    );
  end

  // remainders are unique in history, so at most one cell hits
  always_comb begin
    any_hit = |hit;
    hit_pos = '0;
    for (int k = 0; k < N; k++) begin
      if (hit[k]) hit_pos = LW'(k);
    end
  end

  // radix-4 subtract: each cycle removes up to 3 denominators
  assign denx  = {4'd0, den_q};
  assign sub_b = acc_q - (denx << 1);
  assign sub_a = acc_q - denx;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (div_start) state_d = S_DIV;
        else if (accept && !den_zero) state_d = S_CLOSE;
      end
      S_DIV:   if (div_done) state_d = S_CHECK;
      S_CHECK: begin
        if (rem_q == '0 || idx_q >= limit || any_hit) state_d = S_CLOSE;
        else state_d = S_SUB;
      end
      S_SUB:   if (acc_q < denx) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_CHECK;
      S_CLOSE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    opay_d = '0;
    if (state_q == S_CLOSE) begin
      opay_d.quotient     = whole_q;
      opay_d.status       = st_q;
      opay_d.period_start = pstart_q;
      opay_d.digit_count  = idx_q;
      opay_d.is_last      = 1'b1;
    end else if (state_q == S_EMIT) begin
      opay_d.digit = dig_q;
    end else if (den_zero) begin
      opay_d.status  = dexp_pkg::StDivZero;
      opay_d.is_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) ovld_q <= 1'b1;
      else if (out_if.ready) ovld_q <= 1'b0;
      // a zero numerator counts its single zero digit
      if (accept) idx_q <= (num_zero && !den_zero) ? LW'(1) : '0;
      else if (state_q == S_EMIT && out_free) idx_q <= idx_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) opay_q <= opay_d;
    if (accept) begin
      den_q    <= in_if.payload.denominator;
      whole_q  <= '0;
      rem_q    <= '0;
      st_q     <= dexp_pkg::StExact;
      pstart_q <= '0;
    end else if (state_q == S_DIV && div_done) begin
      whole_q <= div_quo;
      rem_q   <= div_rem;
    end else if (state_q == S_CHECK) begin
      acc_q <= {1'b0, rem_q, 3'd0} + {3'd0, rem_q, 1'b0};
      dig_q <= '0;
      if (rem_q == '0) st_q <= dexp_pkg::StExact;
      else if (idx_q >= limit) st_q <= dexp_pkg::StLoss;
      else if (any_hit) begin
        st_q     <= dexp_pkg::StPeriod;
        pstart_q <= idx_q - LW'(1) - hit_pos;
      end
    end else if (state_q == S_SUB && !(acc_q < denx)) begin
      if (!sub_b[W+3] && sub_b >= denx) begin
        acc_q <= sub_b - denx;
        dig_q <= dig_q + 4'd3;
      end else if (!sub_a[W+3] && sub_a >= denx) begin
        acc_q <= sub_b;
        dig_q <= dig_q + 4'd2;
      end else begin
        acc_q <= sub_a;
        dig_q <= dig_q + 4'd1;
      end
    end else if (state_q == S_EMIT && out_free) begin
      rem_q <= acc_q[W-1:0];
    end
  end

  assign out_if.valid   = ovld_q;
  assign out_if.payload = opay_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.payload))
    else $error("output item changed while stalled");
  a_idx_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LW'(N))
    else $error("digit index beyond history depth");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> dig_q <= 4'd9)
    else $error("digit out of range");
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("remainder recorded twice");
`endif
endmodule

// ===== bench/dexp_bench_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dexp_bench_if
// Channel interfaces are taken from the design; this file only holds the
// bench-side digit limit helper shared by the scoreboard.
// ----------------------------------------------------------------------------
package dexp_bench_pkg;

  // effective digit limit as the block applies it
  function automatic int unsigned eff_limit(input logic [5:0] reg_val);
    if (reg_val == 0) begin
      return 1;
    end
    if (reg_val > dexp_pkg::MaxFracDigits) begin
      return dexp_pkg::MaxFracDigits;
    end
    return 32'(reg_val);
  endfunction

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the decimal expansion block: drives numerator/denominator items
// and limit writes, predicts digit and closing items and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;

  class expansion_board;
    dexp_pkg::out_item_t pending[$];
    logic [5:0]  limit_reg = 6'd32;
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned periodic_seen = 0;
    int unsigned loss_seen = 0;

    function void note_item(dexp_pkg::in_item_t it);
      logic [63:0]  hist[dexp_pkg::MaxFracDigits];
      logic [63:0]  rem;
      logic [127:0] wide;
      logic [1:0]   st;
      dexp_pkg::out_item_t o;
      int unsigned  lim, idx, pstart;
      bit           hit;
      lim = dexp_bench_pkg::eff_limit(limit_reg);
      idx = 0;
      pstart = 0;
      if (it.denominator == 0) begin
        o = '0;
        o.status = dexp_pkg::StDivZero;
        o.is_last = 1'b1;
        pending = {pending, o};
        return;
      end
      if (it.numerator == 0) begin
        o = '0;
        pending = {pending, o};
        o.digit_count = 6'd1;
        o.is_last = 1'b1;
        pending = {pending, o};
        return;
      end
      rem = it.numerator % it.denominator;
      forever begin
        hit = 0;
        if (rem == 0) begin
          st = dexp_pkg::StExact;
          break;
        end
        if (idx >= lim) begin
          st = dexp_pkg::StLoss;
          break;
        end
        for (int i = 0; i < idx; i++) begin
          if (!hit && hist[i] == rem) begin
            hit = 1;
            pstart = i;
          end
        end
        if (hit) begin
          st = dexp_pkg::StPeriod;
          break;
        end
        hist[idx] = rem;
        wide = {64'd0, rem} * 128'd10;
        o = '0;
        o.digit = 4'(wide / {64'd0, it.denominator});
        rem = 64'(wide % {64'd0, it.denominator});
        pending = {pending, o};
        idx++;
      end
      if (st == dexp_pkg::StPeriod) periodic_seen++;
      if (st == dexp_pkg::StLoss) loss_seen++;
      o = '0;
      o.quotient = it.numerator / it.denominator;
      o.status = st;
      o.period_start = 6'(pstart);
      o.digit_count = 6'(idx);
      o.is_last = 1'b1;
      pending = {pending, o};
    endfunction

    function void check_result(dexp_pkg::out_item_t got);
      dexp_pkg::out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  dexp_in_if  in_if();
  dexp_out_if out_if();
  dexp_cfg_if cfg_if();
  expansion_board board;
  int unsigned src_idle = 15, snk_idle = 60;
  int unsigned quiet = 0;
  int unsigned items_sent = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  decimal_expansion_with_repetend i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // receiver with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) board.check_result(out_if.payload);
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet > 20000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back items and drops only while idling
  task automatic send_pair(input logic [63:0] num, input logic [63:0] den);
    dexp_pkg::in_item_t it;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    it.numerator = num;
    it.denominator = den;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic write_limit(input logic [5:0] val);
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (240) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.limit_reg = val;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_pair();
    logic [63:0] num, den;
    case ($urandom_range(4))
      0: begin
        num = {$urandom, $urandom};
        den = {$urandom, $urandom};
      end
      1: begin
        // small divisors give periodic expansions
        num = 64'($urandom_range(1000));
        den = 64'($urandom_range(1, 60));
      end
      2: begin
        num = {$urandom, $urandom};
        den = 64'($urandom_range(1, 400));
      end
      3: begin
        num = {$urandom, $urandom} >> $urandom_range(63);
        den = {$urandom, $urandom} >> $urandom_range(63);
      end
      default: begin
        num = $urandom_range(3) == 0 ? 64'd0 : 64'(~$urandom);
        den = $urandom_range(5) == 0 ? 64'd0 : {$urandom, $urandom};
      end
    endcase
    send_pair(num, den);
  endtask

  initial begin
    board = new();
    in_if.valid = 0;
    in_if.payload = '0;
    cfg_if.valid = 0;
    cfg_if.payload = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero cases and each stop reason
    send_pair(64'd0, 64'd0);
    send_pair(64'd5, 64'd0);
    send_pair(64'd0, 64'd7);
    send_pair('1, 64'd1);
    send_pair('1, '1);
    send_pair(64'd1, '1);
    send_pair('1 - 1, '1);
    send_pair(64'd1, 64'd8);
    send_pair(64'd1, 64'd3);
    send_pair(64'd1, 64'd7);
    send_pair(64'd1, 64'd6);
    send_pair(64'd22, 64'd7);
    send_pair(64'd1, 64'd97);
    send_pair(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFD);
    send_pair(64'd1, 64'd1024);

    write_limit(6'd0);
    send_pair(64'd1, 64'd3);
    send_pair(64'd1, 64'd2);
    write_limit(6'd63);
    send_pair(64'd1, 64'd97);
    write_limit(6'd1);
    send_pair(64'd1, 64'd4);
    write_limit(6'd6);
    send_pair(64'd1, 64'd7);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle = 60;
        snk_idle = 15;
      end else if (ph == 2) begin
        src_idle = 0;
        snk_idle = 0;
      end
      write_limit(ph == 0 ? 6'd32 : 6'($urandom_range(63)));
      repeat (35) random_pair();
    end

    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d input items, %0d output items checked", items_sent,
             board.checked);
    $display("periodic closings %0d, precision-loss closings %0d",
             board.periodic_seen, board.loss_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== decimal_expansion_with_repetend.f =====
sv/dexp_pkg.sv
sv/dexp_if.sv
sv/dexp_cell.sv
sv/dexp_divider.sv
sv/decimal_expansion_with_repetend.sv
bench/dexp_bench_if.sv
bench/tb_top.sv
